[design/sit_pkg.sv]
// Shared types, codes and defaults for the sorted insert table.
package sit_pkg;

    // Built defaults for the top-level parameters.
    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed field widths of the item and result ports.
    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 5;

    // Value of the capacity limit register after reset.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADIDX = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the offered item
        logic execute;  // apply the latched item and load the result register
    } sit_cmd_t;

endpackage

[design/sorted_insert_table.sv]
// Top level of the sorted insert table: controller and datapath.
// The controller takes an item only while idle and latches it, then applies it to the row
// of entry cells, all cells comparing and shifting in parallel, and loads the result register;
// no new item is taken until the latched one has been applied.
// A result waiting at the output holds the next item in its apply cycle until taken.
// Reset clears the entry count and sets the capacity limit to 16; entry contents are not reset.
module sorted_insert_table #(
    parameter int CAPACITY    = sit_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = sit_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sit_pkg::LIMIT_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sit_pkg::MODE_W-1:0]    s_mode,
    input  logic [sit_pkg::VALUE_W-1:0]   s_value,
    input  logic [sit_pkg::INDEX_W-1:0]   s_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sit_pkg::VALUE_W-1:0]   m_read_value,
    output logic [sit_pkg::COUNT_W-1:0]   m_entry_count,
    output logic [sit_pkg::POS_W-1:0]     m_insert_position,
    output logic [sit_pkg::STATUS_W-1:0]  m_status
);
    import sit_pkg::*;

    sit_cmd_t cmd;

    // Sequencing of accept, apply and result handover.
    sit_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Entry cells, count, limit and result register.
    sit_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_mode            (s_mode),
        .s_value           (s_value),
        .s_index           (s_index),
        .m_read_value      (m_read_value),
        .m_entry_count     (m_entry_count),
        .m_insert_position (m_insert_position),
        .m_status          (m_status)
    );

endmodule

[design/sit_ctrl.sv]
// Controller state machine for the sorted insert table.
module sit_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output sit_pkg::sit_cmd_t cmd
);
    import sit_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // An item is taken only while idle; it is applied once the result register is free.
    always_comb begin
        cmd.capture  = (state_reg == ST_IDLE) && s_valid;
        cmd.execute  = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[design/sit_datapath.sv]
// Datapath of the sorted insert table: row of entry cells, count, limit and result register.
module sit_datapath #(
    parameter int CAPACITY    = sit_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = sit_pkg::DEF_VALUE_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  sit_pkg::sit_cmd_t                cmd,
    input  logic                             cfg_wr_en,
    input  logic [sit_pkg::LIMIT_W-1:0]      cfg_wr_data,
    input  logic [sit_pkg::MODE_W-1:0]       s_mode,
    input  logic [sit_pkg::VALUE_W-1:0]      s_value,
    input  logic [sit_pkg::INDEX_W-1:0]      s_index,
    output logic [sit_pkg::VALUE_W-1:0]      m_read_value,
    output logic [sit_pkg::COUNT_W-1:0]      m_entry_count,
    output logic [sit_pkg::POS_W-1:0]        m_insert_position,
    output logic [sit_pkg::STATUS_W-1:0]     m_status
);
    import sit_pkg::*;

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = $clog2(CAPACITY);
    localparam int LW  = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int NRD = (CAPACITY < (1 << INDEX_W)) ? CAPACITY : (1 << INDEX_W);

    // Latched item.
    logic [MODE_W-1:0]      mode_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [INDEX_W-1:0]     index_reg;

    // Table state.
    logic [VALUE_WIDTH-1:0] entry_reg [CAPACITY];
    logic [CW-1:0]          count_reg;
    logic [LIMIT_W-1:0]     limit_reg;

    // Result register.
    logic [VALUE_W-1:0]  rd_reg;
    logic [COUNT_W-1:0]  cnt_out_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [63:0]            value_wide;
    logic [VALUE_WIDTH-1:0] ins_next [CAPACITY];
    logic [VALUE_WIDTH-1:0] rem_next [CAPACITY];
    logic [CAPACITY-1:0]    gt;
    logic [CAPACITY-1:0]    gt_prev;
    logic [CAPACITY-1:0]    boundary;
    logic [PW-1:0]          ins_pos;
    logic [VALUE_WIDTH-1:0] lookup_val;
    logic [LW-1:0]          count_l;
    logic [LW-1:0]          index_l;
    logic [LW-1:0]          eff_limit;
    logic                   is_full;
    logic                   is_bad;
    logic                   do_insert;
    logic                   do_remove;
    logic [CW-1:0]          count_next;
    logic [PW-1:0]          pos_next;
    logic [VALUE_WIDTH-1:0] rd_next;
    logic [STATUS_W-1:0]    status_next;
    logic [15:0]            count_wide;
    logic [15:0]            pos_wide;
    logic [63:0]            rd_wide;

    // Stored values are the low bits of the input value.
    assign value_wide = 64'(s_value);

    // Each cell compares its entry with the new value; the mask is a prefix of ones.
    assign gt_prev  = {gt[CAPACITY-2:0], 1'b1};
    assign boundary = gt_prev & ~gt;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign gt[g] = (count_reg > CW'(g)) && (value_reg < entry_reg[g]);

        // Insert: larger entries stay, the boundary cell takes the value, the rest move down.
        if (g == 0) begin : g_head
            assign ins_next[g] = gt[g] ? entry_reg[g] : value_reg;
        end else begin : g_body
            assign ins_next[g] = gt[g]      ? entry_reg[g]   :
                                 gt_prev[g] ? value_reg      : entry_reg[g-1];
        end

        // Remove: cells at or past the index take their successor; the last cell keeps.
        if (g == CAPACITY - 1) begin : g_tail
            assign rem_next[g] = entry_reg[g];
        end else begin : g_shift
            assign rem_next[g] = (LW'(g) >= index_l) ? entry_reg[g+1] : entry_reg[g];
        end
    end

    // Encode the boundary cell as the insert position.
    always_comb begin
        ins_pos = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (boundary[k]) begin
                ins_pos = ins_pos | PW'(k);
            end
        end
    end

    // Lookup reads one of the cells the index can reach.
    always_comb begin
        lookup_val = '0;
        for (int k = 0; k < NRD; k++) begin
            if (index_reg == INDEX_W'(k)) begin
                lookup_val = entry_reg[k];
            end
        end
    end

    // Refusal checks against the count and the clipped limit.
    assign count_l   = LW'(count_reg);
    assign index_l   = LW'(index_reg);
    assign eff_limit = (LW'(limit_reg) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(limit_reg);
    assign is_full   = count_l >= eff_limit;
    assign is_bad    = index_l >= count_l;

    // Result and count for the latched operation.
    always_comb begin
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        count_next  = count_reg;
        pos_next    = '0;
        rd_next     = '0;
        status_next = STATUS_DONE;
        unique case (mode_reg)
            MODE_INSERT: begin
                if (is_full) begin
                    status_next = STATUS_FULL;
                end else begin
                    do_insert  = 1'b1;
                    count_next = count_reg + CW'(1);
                    pos_next   = ins_pos;
                end
            end
            MODE_LOOKUP: begin
                if (is_bad) begin
                    status_next = STATUS_BADIDX;
                end else begin
                    rd_next = lookup_val;
                end
            end
            MODE_REMOVE: begin
                if (is_bad) begin
                    status_next = STATUS_BADIDX;
                end else begin
                    do_remove  = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            default: begin
                status_next = STATUS_DONE;
            end
        endcase
    end

    // Fit internal widths to the result fields.
    assign count_wide = 16'(count_next);
    assign pos_wide   = 16'(pos_next);
    assign rd_wide    = 64'(rd_next);

    // Control state: entry count and capacity limit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
        end else begin
            if (cmd.execute) begin
                count_reg <= count_next;
            end
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // Payload: latched item, entry cells and result register.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= s_mode;
            value_reg <= value_wide[VALUE_WIDTH-1:0];
            index_reg <= s_index;
        end
        if (cmd.execute) begin
            if (do_insert) begin
                entry_reg <= ins_next;
            end else if (do_remove) begin
                entry_reg <= rem_next;
            end
            rd_reg      <= rd_wide[VALUE_W-1:0];
            cnt_out_reg <= count_wide[COUNT_W-1:0];
            pos_reg     <= pos_wide[POS_W-1:0];
            status_reg  <= status_next;
        end
    end

    assign m_read_value      = rd_reg;
    assign m_entry_count     = cnt_out_reg;
    assign m_insert_position = pos_reg;
    assign m_status          = status_reg;

endmodule

[tb/tb_sorted_insert_table.sv]
// Self-checking testbench for the sorted insert table: random and directed items against a mirror.
module tb_sorted_insert_table;
    timeunit 1ns;
    timeprecision 1ps;

    import sit_pkg::*;

    localparam int CAP = DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENT_ITEMS = 211;
    // The fourth mode code has no operation behind it.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // One result item as the block reports it.
    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [COUNT_W-1:0]  entry_count;
        logic [POS_W-1:0]    insert_position;
        logic [STATUS_W-1:0] status;
    } table_result_t;

    // Mirror of the table contents, with the results still owed by the block.
    class sorted_table_mirror;
        logic [VALUE_W-1:0] entries [CAP];
        logic [COUNT_W-1:0] fill;
        logic [LIMIT_W-1:0] limit;
        table_result_t      owed_results [$];
        int                 mismatches;
        int                 items_seen;
        int                 checked;
        int                 status_seen [4];

        function new();
            foreach (entries[k]) entries[k] = '0;
            fill = '0;
            limit = LIMIT_RESET;
            mismatches = 0;
            items_seen = 0;
            checked = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] lim);
            limit = lim;
        endfunction

        // Apply one accepted item to the mirror and queue the result it must give.
        function void note_item(logic [MODE_W-1:0] op, logic [VALUE_W-1:0] val,
                                logic [INDEX_W-1:0] idx);
            table_result_t r;
            int eff;
            int pos;
            int k;
            int n;
            r = '0;
            r.status = STATUS_DONE;
            eff = (limit > CAP) ? CAP : int'(limit);
            n = int'(fill);
            items_seen++;
            case (op)
                MODE_INSERT: begin
                    if (n >= eff) begin
                        r.status = STATUS_FULL;
                    end else begin
                        // Step over every entry strictly larger than the new value.
                        pos = 0;
                        while (pos < n && val < entries[pos]) pos++;
                        for (k = n; k > pos; k--) entries[k] = entries[k-1];
                        entries[pos] = val;
                        n++;
                        r.insert_position = pos[POS_W-1:0];
                    end
                end
                MODE_LOOKUP: begin
                    if (int'(idx) >= n) r.status = STATUS_BADIDX;
                    else r.read_value = entries[idx];
                end
                MODE_REMOVE: begin
                    if (int'(idx) >= n) begin
                        r.status = STATUS_BADIDX;
                    end else begin
                        // Close the gap; the freed tail slot keeps its old value.
                        for (k = int'(idx); k + 1 < n; k++) entries[k] = entries[k+1];
                        n--;
                    end
                end
                default: begin
                end
            endcase
            fill = n[COUNT_W-1:0];
            r.entry_count = fill;
            owed_results.push_back(r);
        endfunction

        function void report(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        endfunction

        // Compare one accepted result with the oldest one owed.
        function void check_result(table_result_t got);
            table_result_t want;
            if (owed_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got %h", $time, got);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got.read_value !== want.read_value)
                report("read_value", want.read_value, got.read_value);
            if (got.entry_count !== want.entry_count)
                report("entry_count", VALUE_W'(want.entry_count), VALUE_W'(got.entry_count));
            if (got.insert_position !== want.insert_position)
                report("insert_position", VALUE_W'(want.insert_position),
                       VALUE_W'(got.insert_position));
            if (got.status !== want.status)
                report("status", VALUE_W'(want.status), VALUE_W'(got.status));
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0]  cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [MODE_W-1:0]   s_mode = MODE_INSERT;
    logic [VALUE_W-1:0]  s_value = '0;
    logic [INDEX_W-1:0]  s_index = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [VALUE_W-1:0]  m_read_value;
    logic [COUNT_W-1:0]  m_entry_count;
    logic [POS_W-1:0]    m_insert_position;
    logic [STATUS_W-1:0] m_status;

    sorted_table_mirror mirror;
    int  send_gap_pct = 0;
    int  take_gap_pct = 0;
    int  cycle_count = 0;
    bit  growing = 1'b1;
    logic [LIMIT_W-1:0] limit_plan [9] = '{5'd16, 5'd31, 5'd5, 5'd1, 5'd0,
                                           5'd17, 5'd9, 5'd16, 5'd12};

    sorted_insert_table uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_value           (s_value),
        .s_index           (s_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_value      (m_read_value),
        .m_entry_count     (m_entry_count),
        .m_insert_position (m_insert_position),
        .m_status          (m_status)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Overall time limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("sorted_insert_table regression: fail");
            $finish;
        end
    end

    // Result side: random back-pressure, checked on every accepted item.
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(0, 99) >= take_gap_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            mirror.check_result('{m_read_value, m_entry_count, m_insert_position, m_status});
    end

    // Offer one item, with random gaps before it, and hold it until accepted.
    task automatic send_item(logic [MODE_W-1:0] op, logic [VALUE_W-1:0] val,
                             logic [INDEX_W-1:0] idx);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= op;
        s_value <= val;
        s_index <= idx;
        do @(posedge aclk); while (!s_ready);
        mirror.note_item(op, val, idx);
    endtask

    // Stop offering and let every owed result come back.
    task automatic wait_settled();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (mirror.owed_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Capacity limit write; only called while the block is idle.
    task automatic write_limit(logic [LIMIT_W-1:0] lim);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge aclk);
        mirror.set_limit(lim);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Edge cases: empty table, extremes, duplicates, head/tail/middle removal, full table.
    task automatic run_directed();
        send_item(MODE_LOOKUP, 32'h0, 4'd0);
        send_item(MODE_REMOVE, 32'hFFFF_FFFF, 4'd15);
        send_item(MODE_UNUSED, 32'h0, 4'd0);
        send_item(MODE_INSERT, 32'h0, 4'd0);
        send_item(MODE_INSERT, 32'hFFFF_FFFF, 4'd15);
        send_item(MODE_INSERT, 32'h8000_0000, 4'd0);
        send_item(MODE_INSERT, 32'h8000_0000, 4'd0);
        send_item(MODE_INSERT, 32'h1, 4'd0);
        send_item(MODE_INSERT, 32'h0, 4'd0);
        send_item(MODE_LOOKUP, 32'h0, 4'd0);
        send_item(MODE_LOOKUP, 32'h0, 4'd5);
        send_item(MODE_LOOKUP, 32'h0, 4'd6);
        send_item(MODE_REMOVE, 32'h0, 4'd0);
        send_item(MODE_REMOVE, 32'h0, 4'd4);
        send_item(MODE_REMOVE, 32'h0, 4'd1);
        send_item(MODE_LOOKUP, 32'h0, 4'd15);
        // Limit lowered below the current count: inserts refused, entries kept.
        wait_settled();
        write_limit(5'd2);
        send_item(MODE_INSERT, 32'h7, 4'd0);
        send_item(MODE_LOOKUP, 32'h0, 4'd2);
        send_item(MODE_UNUSED, 32'hFFFF_FFFF, 4'd15);
        send_item(MODE_REMOVE, 32'h0, 4'd2);
        send_item(MODE_INSERT, 32'h5, 4'd0);
        wait_settled();
        write_limit(5'd3);
        send_item(MODE_INSERT, 32'h5, 4'd0);
        send_item(MODE_INSERT, 32'h6, 4'd0);
    endtask

    // Random item that walks the count up to the limit and back down to empty.
    task automatic offer_random_item();
        int eff;
        int roll;
        logic [MODE_W-1:0]  op;
        logic [VALUE_W-1:0] val;
        logic [INDEX_W-1:0] idx;
        eff = (mirror.limit > CAP) ? CAP : int'(mirror.limit);
        if (growing && mirror.fill >= eff) growing = 1'b0;
        else if (!growing && mirror.fill == 0) growing = 1'b1;
        roll = $urandom_range(0, 99);
        if (growing)
            op = (roll < 60) ? MODE_INSERT : (roll < 78) ? MODE_LOOKUP :
                 (roll < 97) ? MODE_REMOVE : MODE_UNUSED;
        else
            op = (roll < 12) ? MODE_INSERT : (roll < 30) ? MODE_LOOKUP :
                 (roll < 97) ? MODE_REMOVE : MODE_UNUSED;
        // Favour extremes, values already stored and a narrow range to get ties.
        case ($urandom_range(0, 9))
            0: val = '0;
            1: val = '1;
            2, 3: begin
                if (mirror.fill != 0) val = mirror.entries[$urandom_range(0, mirror.fill - 1)];
                else val = $urandom;
            end
            4, 5: val = $urandom_range(0, 7);
            default: val = $urandom;
        endcase
        if (mirror.fill != 0 && $urandom_range(0, 3) != 0)
            idx = INDEX_W'($urandom_range(0, mirror.fill - 1));
        else
            idx = INDEX_W'($urandom_range(0, 15));
        send_item(op, val, idx);
    endtask

    // Main sequence.
    initial begin
        mirror = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();

        // Three idling profiles, three limit settings each.
        for (int seg = 0; seg < 9; seg++) begin
            case (seg / 3)
                0: begin
                    send_gap_pct = 37;
                    take_gap_pct = 46;
                end
                1: begin
                    send_gap_pct = 46;
                    take_gap_pct = 37;
                end
                default: begin
                    send_gap_pct = 0;
                    take_gap_pct = 0;
                end
            endcase
            wait_settled();
            write_limit(limit_plan[seg]);
            for (int i = 0; i < SEGMENT_ITEMS; i++) begin
                if (i == SEGMENT_ITEMS / 2) wait_settled();
                offer_random_item();
            end
        end

        wait_settled();
        repeat (4) @(posedge aclk);
        $display("Covered %0d items across 9 capacity settings and three idling profiles;",
                 mirror.items_seen);
        $display("%0d results checked: %0d done, %0d full refusals, %0d bad-index refusals.",
                 mirror.checked, mirror.status_seen[STATUS_DONE],
                 mirror.status_seen[STATUS_FULL], mirror.status_seen[STATUS_BADIDX]);
        if (mirror.mismatches == 0) begin
            $display("sorted_insert_table regression: pass");
        end else begin
            $display("sorted_insert_table regression: fail");
        end
        $finish;
    end

endmodule
